>>> rtl/five_bar_leg_forward_kinematics_macros.svh
// Concurrent assertion shorthands on clk; NOW, NEXT disabled in reset.
`ifndef FIVE_BAR_LEG_FORWARD_KINEMATICS_MACROS_SVH
`define FIVE_BAR_LEG_FORWARD_KINEMATICS_MACROS_SVH

// same-cycle implication
`define FBL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// holds in the cycle after reset is seen
`define FBL_ASSERT_RST(name, cons, msg) \
  name: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

>>> rtl/fblfk_pkg.sv
package fblfk_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int ANG_SHIFT     = 32 - ANGLE_BITS;
  localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << ANG_SHIFT;

  localparam int LEN_W = 14;
  localparam int ROT_W = 33;
  localparam int RZ_W  = 34;
  localparam int VIN_W = 36;
  localparam int VEC_W = 38;
  localparam int POS_W = 34;
  localparam int DIF_W = 36;
  localparam int C_W   = 64;
  localparam int NRM_W = 31;
  localparam int SQ_W  = 62;
  localparam int LP_W  = 68;

  localparam logic signed [ROT_W-1:0] INV_GAIN = 33'sd652032874;
  localparam logic signed [RZ_W-1:0]  HALF_TURN = 34'sh0_8000_0000;
  localparam logic signed [RZ_W-1:0]  QUARTER_TURN = 34'sh0_4000_0000;

  localparam logic [2:0] REG_UPPER_A   = 3'd0;
  localparam logic [2:0] REG_LOWER_A   = 3'd1;
  localparam logic [2:0] REG_LOWER_B   = 3'd2;
  localparam logic [2:0] REG_UPPER_B   = 3'd3;
  localparam logic [2:0] REG_SPACING   = 3'd4;

  localparam logic [LEN_W-1:0] RST_UPPER_A = 14'd1500;
  localparam logic [LEN_W-1:0] RST_LOWER_A = 14'd2500;
  localparam logic [LEN_W-1:0] RST_LOWER_B = 14'd2500;
  localparam logic [LEN_W-1:0] RST_UPPER_B = 14'd1500;
  localparam logic [LEN_W-1:0] RST_SPACING = 14'd1000;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [POS_W-1:0] xb;
    logic signed [POS_W-1:0] yb;
    logic signed [POS_W-1:0] xd;
    logic signed [POS_W-1:0] yd;
    logic                    unreach;
  } geo_t;

  typedef struct packed {
    logic signed [C_W-1:0] a;
    logic signed [C_W-1:0] b;
    logic signed [C_W-1:0] c;
  } wide_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] an;
    logic signed [NRM_W-1:0] bn;
    logic signed [NRM_W-1:0] cn;
  } nrm_t;

  typedef struct packed {
    logic signed [POS_W-1:0] wx;
    logic signed [POS_W-1:0] wy;
    logic                    unreach;
  } whl_t;

  function automatic logic [31:0] atan_step(input int i);
    logic [32:0] t;
    t = {1'b0, ATAN_TAB[i]} + (33'd1 << (ANG_SHIFT - 1));
    t = (t >> ANG_SHIFT) << ANG_SHIFT;
    return t[31:0];
  endfunction

  function automatic logic [15:0] pos_sat(input logic signed [POS_W-1:0] q);
    logic signed [POS_W-1:0] v;
    v = (q + 34'sd32768) >>> 16;
    if (v > 34'sd32767) return 16'h7FFF;
    else if (v < -34'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  function automatic logic [15:0] ang_round(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h0000_8000;
    return t[31:16];
  endfunction

endpackage

>>> rtl/fblfk_rot.sv
module fblfk_rot import fblfk_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [31:0]             ang,
  output logic signed [ROT_W-1:0] cos_o,
  output logic signed [ROT_W-1:0] sin_o
);

  logic signed [ROT_W-1:0] x_r [CORDIC_STAGES];
  logic signed [ROT_W-1:0] y_r [CORDIC_STAGES];
  logic signed [RZ_W-1:0]  z_r [CORDIC_STAGES];
  logic signed [ROT_W-1:0] x0;
  logic signed [RZ_W-1:0]  z0;

  always_comb begin
    z0 = $signed({{2{ang[31]}}, ang});
    x0 = INV_GAIN;
    if (z0 > QUARTER_TURN) begin
      z0 = z0 - HALF_TURN;
      x0 = -INV_GAIN;
    end else if (z0 < -QUARTER_TURN) begin
      z0 = z0 + HALF_TURN;
      x0 = -INV_GAIN;
    end
  end

  genvar g;
  for (g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic signed [ROT_W-1:0] xi;
    logic signed [ROT_W-1:0] yi;
    logic signed [RZ_W-1:0]  zi;
    logic signed [RZ_W-1:0]  st;
    if (g == 0) begin : g_first
      assign xi = x0;
      assign yi = '0;
      assign zi = z0;
    end else begin : g_rest
      assign xi = x_r[g-1];
      assign yi = y_r[g-1];
      assign zi = z_r[g-1];
    end
    assign st = $signed({2'b00, atan_step(g)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          x_r[g] <= xi - (yi >>> g);
          y_r[g] <= yi + (xi >>> g);
          z_r[g] <= zi - st;
        end else begin
          x_r[g] <= xi + (yi >>> g);
          y_r[g] <= yi - (xi >>> g);
          z_r[g] <= zi + st;
        end
      end
    end
  end

  assign cos_o = x_r[CORDIC_STAGES-1];
  assign sin_o = y_r[CORDIC_STAGES-1];

endmodule

>>> rtl/fblfk_vec.sv
module fblfk_vec import fblfk_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VIN_W-1:0] x_i,
  input  logic signed [VIN_W-1:0] y_i,
  output logic [31:0]             ang_o,
  output logic signed [VEC_W-1:0] mag_o
);

  logic signed [VEC_W-1:0] x_r [CORDIC_STAGES];
  logic signed [VEC_W-1:0] y_r [CORDIC_STAGES];
  logic signed [RZ_W-1:0]  z_r [CORDIC_STAGES];
  logic                    zf_r [CORDIC_STAGES];
  logic signed [VEC_W-1:0] x0;
  logic signed [VEC_W-1:0] y0;
  logic signed [RZ_W-1:0]  z0;
  logic                    zf0;

  always_comb begin
    x0  = VEC_W'(x_i);
    y0  = VEC_W'(y_i);
    z0  = '0;
    zf0 = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x0 = -x0;
      y0 = -y0;
      z0 = HALF_TURN;
    end
  end

  genvar g;
  for (g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic signed [VEC_W-1:0] xi;
    logic signed [VEC_W-1:0] yi;
    logic signed [RZ_W-1:0]  zi;
    logic                    zfi;
    logic signed [RZ_W-1:0]  st;
    if (g == 0) begin : g_first
      assign xi  = x0;
      assign yi  = y0;
      assign zi  = z0;
      assign zfi = zf0;
    end else begin : g_rest
      assign xi  = x_r[g-1];
      assign yi  = y_r[g-1];
      assign zi  = z_r[g-1];
      assign zfi = zf_r[g-1];
    end
    assign st = $signed({2'b00, atan_step(g)});
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[g] <= zfi;
        if (yi < 0) begin
          x_r[g] <= xi - (yi >>> g);
          y_r[g] <= yi + (xi >>> g);
          z_r[g] <= zi - st;
        end else begin
          x_r[g] <= xi + (yi >>> g);
          y_r[g] <= yi - (xi >>> g);
          z_r[g] <= zi + st;
        end
      end
    end
  end

  assign ang_o = zf_r[CORDIC_STAGES-1] ? 32'h0 : z_r[CORDIC_STAGES-1][31:0];
  assign mag_o = zf_r[CORDIC_STAGES-1] ? '0 : x_r[CORDIC_STAGES-1];

endmodule

>>> rtl/fblfk_sqrt.sv
module fblfk_sqrt import fblfk_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] d_i,
  output logic [31:0] root_o
);

  logic [63:0] v_r [32];
  logic [63:0] r_r [32];

  genvar g;
  for (g = 0; g < 32; g++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] vi;
    logic [63:0] ri;
    logic [63:0] tr;
    if (g == 0) begin : g_first
      assign vi = d_i;
      assign ri = '0;
    end else begin : g_rest
      assign vi = v_r[g-1];
      assign ri = r_r[g-1];
    end
    assign tr = ri + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= tr) begin
          v_r[g] <= vi - tr;
          r_r[g] <= (ri >> 1) + BIT;
        end else begin
          v_r[g] <= vi;
          r_r[g] <= ri >> 1;
        end
      end
    end
  end

  assign root_o = r_r[31][31:0];

endmodule

>>> rtl/five_bar_leg_forward_kinematics.sv
// The pipeline has 4*CORDIC_STAGES + 47 register stages (111 at 16 stages). Four CORDIC
// pipelines stand in series (joint rotation, half-angle vectoring, knee rotation, output
// vectoring) plus the 32-stage root.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous active-low rst_n clears valid bits, loads default link lengths
// and holds off the input and configuration channels.
module five_bar_leg_forward_kinematics import fblfk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_joint_a_angle,
  input  logic signed [15:0] in_joint_b_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_wheel_x,
  output logic signed [15:0] out_wheel_y,
  output logic [15:0]        out_leg_length,
  output logic signed [15:0] out_leg_angle,
  output logic signed [15:0] out_angle_one,
  output logic signed [15:0] out_angle_two,
  output logic signed [15:0] out_angle_three,
  output logic signed [15:0] out_angle_four,
  output logic               out_unreachable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [LEN_W-1:0]   cfg_data
);

  localparam int N    = CORDIC_STAGES;
  localparam int LAT  = 4 * N + 47;
  localparam int GDLY = 2 * N + 34;
  localparam int PDLY = 2 * N + 3;

  logic [LEN_W-1:0] upper_link_a_r, lower_link_a_r, lower_link_b_r;
  logic [LEN_W-1:0] upper_link_b_r, motor_spacing_r;
  logic [LAT-1:0]   vld_r;
  logic             en;

  assign cfg_ready = rst_n;
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !rst_n || !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_link_a_r  <= RST_UPPER_A;
      lower_link_a_r  <= RST_LOWER_A;
      lower_link_b_r  <= RST_LOWER_B;
      upper_link_b_r  <= RST_UPPER_B;
      motor_spacing_r <= RST_SPACING;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER_A: upper_link_a_r  <= cfg_data;
        REG_LOWER_A: lower_link_a_r  <= cfg_data;
        REG_LOWER_B: lower_link_b_r  <= cfg_data;
        REG_UPPER_B: upper_link_b_r  <= cfg_data;
        REG_SPACING: motor_spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [LEN_W:0]   l1s, l2s, l3s, l4s;
  logic signed [LEN_W+1:0] l2x2;
  assign l1s  = $signed({1'b0, upper_link_a_r});
  assign l2s  = $signed({1'b0, lower_link_a_r});
  assign l3s  = $signed({1'b0, lower_link_b_r});
  assign l4s  = $signed({1'b0, upper_link_b_r});
  assign l2x2 = $signed({1'b0, lower_link_a_r, 1'b0});

  // joint rotations
  logic signed [ROT_W-1:0] c1, s1, c4, s4;

  fblfk_rot u_rot_a (
    .clk(clk), .en(en), .ang({in_joint_a_angle, 16'h0} & ANG_MASK),
    .cos_o(c1), .sin_o(s1)
  );

  fblfk_rot u_rot_b (
    .clk(clk), .en(en), .ang({in_joint_b_angle, 16'h0} & ANG_MASK),
    .cos_o(c4), .sin_o(s4)
  );

  // link end points
  geo_t                    g1_nxt;
  geo_t                    gp_r [8];
  logic signed [47:0]      m_xb, m_yb, m_xd, m_yd;

  always_comb begin
    m_xb = l1s * c1;
    m_yb = l1s * s1;
    m_xd = l4s * c4;
    m_yd = l4s * s4;
    g1_nxt.xb      = POS_W'(m_xb >>> 14);
    g1_nxt.yb      = POS_W'(m_yb >>> 14);
    g1_nxt.xd      = POS_W'(m_xd >>> 14) + $signed({4'b0, motor_spacing_r, 16'h0});
    g1_nxt.yd      = POS_W'(m_yd >>> 14);
    g1_nxt.unreach = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gp_r[0] <= g1_nxt;
      for (int i = 1; i < 8; i++) begin
        gp_r[i] <= gp_r[i-1];
      end
    end
  end

  // knee equation terms
  logic signed [DIF_W-1:0]  dx_r, dy_r;
  logic signed [DIF_W-9:0]  dx8, dy8;
  logic signed [51:0]       a3_r, b3_r;
  logic signed [55:0]       sqx_r, sqy_r;
  logic signed [29:0]       kd_r;
  wide_t                    w4_r, w5_r, w6_r;
  logic [C_W-1:0]           m5_r;
  logic [5:0]               s6_r, s6_nxt;
  nrm_t                     n7_r, n8_r;
  logic signed [SQ_W-1:0]   sqa_r, sqb_r, sqc_r;
  logic [63:0]              d9_r;
  nrm_t                     n9_r;
  geo_t                     g9_r;
  logic signed [C_W-1:0]    d_sum;
  logic signed [C_W-1:0]    aa, ab, ac;

  assign dx8   = dx_r[DIF_W-1:8];
  assign dy8   = dy_r[DIF_W-1:8];
  assign aa    = (w4_r.a < 0) ? -w4_r.a : w4_r.a;
  assign ab    = (w4_r.b < 0) ? -w4_r.b : w4_r.b;
  assign ac    = (w4_r.c < 0) ? -w4_r.c : w4_r.c;
  assign d_sum = C_W'(sqa_r) + C_W'(sqb_r) - C_W'(sqc_r);

  always_comb begin
    s6_nxt = '0;
    for (int i = 30; i < C_W; i++) begin
      if (m5_r[i]) s6_nxt = 6'(i - 29);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DIF_W'($signed(gp_r[0].xd)) - DIF_W'($signed(gp_r[0].xb));
      dy_r  <= DIF_W'($signed(gp_r[0].yd)) - DIF_W'($signed(gp_r[0].yb));
      a3_r  <= l2x2 * dx_r;
      b3_r  <= l2x2 * dy_r;
      sqx_r <= dx8 * dx8;
      sqy_r <= dy8 * dy8;
      kd_r  <= 30'(l2s) * 30'(l2s) - 30'(l3s) * 30'(l3s);
      w4_r.a <= C_W'(a3_r);
      w4_r.b <= C_W'(b3_r);
      w4_r.c <= (C_W'(kd_r) <<< 16) + C_W'(sqx_r) + C_W'(sqy_r);
      w5_r  <= w4_r;
      m5_r  <= aa | ab | ac;
      w6_r  <= w5_r;
      s6_r  <= s6_nxt;
      n7_r.an <= NRM_W'(w6_r.a >>> s6_r);
      n7_r.bn <= NRM_W'(w6_r.b >>> s6_r);
      n7_r.cn <= NRM_W'(w6_r.c >>> s6_r);
      n8_r  <= n7_r;
      sqa_r <= n7_r.an * n7_r.an;
      sqb_r <= n7_r.bn * n7_r.bn;
      sqc_r <= n7_r.cn * n7_r.cn;
      n9_r  <= n8_r;
      d9_r  <= (d_sum < 0) ? 64'd0 : d_sum;
      g9_r  <= '{gp_r[7].xb, gp_r[7].yb, gp_r[7].xd, gp_r[7].yd, d_sum < 0};
    end
  end

  // root and half angle
  logic [31:0]             root;
  nrm_t                    ad_r [32];
  geo_t                    sd_r [GDLY];
  logic signed [VIN_W-1:0] vx_r, vy_r;
  logic [31:0]             half;
  logic [31:0]             phi2;
  logic [31:0]             ph2_r [PDLY];

  fblfk_sqrt u_sqrt (.clk(clk), .en(en), .d_i(d9_r), .root_o(root));

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0] <= n9_r;
      for (int i = 1; i < 32; i++) ad_r[i] <= ad_r[i-1];
      sd_r[0] <= g9_r;
      for (int i = 1; i < GDLY; i++) sd_r[i] <= sd_r[i-1];
      vx_r <= VIN_W'(ad_r[31].an) + VIN_W'(ad_r[31].cn);
      vy_r <= VIN_W'(ad_r[31].bn) + $signed({4'b0, root});
      ph2_r[0] <= phi2;
      for (int i = 1; i < PDLY; i++) ph2_r[i] <= ph2_r[i-1];
    end
  end

  fblfk_vec u_vec_half (
    .clk(clk), .en(en), .x_i(vx_r), .y_i(vy_r), .ang_o(half), .mag_o()
  );

  assign phi2 = {half[30:0], 1'b0};

  logic signed [ROT_W-1:0] c2, s2;

  fblfk_rot u_rot_knee (.clk(clk), .en(en), .ang(phi2), .cos_o(c2), .sin_o(s2));

  // wheel point and solver vectors
  logic signed [47:0]      pc_r, ps_r;
  geo_t                    g12_r;
  whl_t                    w12_r, w13_r;
  whl_t                    wd_r [N];
  logic signed [VIN_W-1:0] vin_x_r [4];
  logic signed [VIN_W-1:0] vin_y_r [4];
  logic signed [VIN_W-1:0] mid_x, base_x;

  assign mid_x  = $signed({7'b0, motor_spacing_r, 15'h0});
  assign base_x = $signed({6'b0, motor_spacing_r, 16'h0});

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r  <= l2s * c2;
      ps_r  <= l2s * s2;
      g12_r <= sd_r[GDLY-1];
      w12_r.wx      <= $signed(sd_r[GDLY-1].xb) + POS_W'(pc_r >>> 14);
      w12_r.wy      <= $signed(sd_r[GDLY-1].yb) + POS_W'(ps_r >>> 14);
      w12_r.unreach <= sd_r[GDLY-1].unreach;
      w13_r <= w12_r;
      vin_x_r[0] <= VIN_W'(w12_r.wx) - mid_x;
      vin_y_r[0] <= VIN_W'(w12_r.wy);
      vin_x_r[1] <= VIN_W'(g12_r.xb);
      vin_y_r[1] <= VIN_W'(g12_r.yb);
      vin_x_r[2] <= VIN_W'(w12_r.wx) - VIN_W'(g12_r.xd);
      vin_y_r[2] <= VIN_W'(w12_r.wy) - VIN_W'(g12_r.yd);
      vin_x_r[3] <= VIN_W'(g12_r.xd) - base_x;
      vin_y_r[3] <= VIN_W'(g12_r.yd);
      wd_r[0] <= w13_r;
      for (int i = 1; i < N; i++) wd_r[i] <= wd_r[i-1];
    end
  end

  logic [31:0]             phi [4];
  logic signed [VEC_W-1:0] mag0;

  fblfk_vec u_vec_leg (
    .clk(clk), .en(en), .x_i(vin_x_r[0]), .y_i(vin_y_r[0]), .ang_o(phi[0]), .mag_o(mag0)
  );
  fblfk_vec u_vec_one (
    .clk(clk), .en(en), .x_i(vin_x_r[1]), .y_i(vin_y_r[1]), .ang_o(phi[1]), .mag_o()
  );
  fblfk_vec u_vec_three (
    .clk(clk), .en(en), .x_i(vin_x_r[2]), .y_i(vin_y_r[2]), .ang_o(phi[2]), .mag_o()
  );
  fblfk_vec u_vec_four (
    .clk(clk), .en(en), .x_i(vin_x_r[3]), .y_i(vin_y_r[3]), .ang_o(phi[3]), .mag_o()
  );

  // output formatting
  logic signed [LP_W-1:0]  lenp_r;
  logic [15:0]             x14_r, y14_r;
  logic [31:0]             ph14_r [5];
  logic                    ur14_r;
  logic signed [LP_W-1:0]  len_t, len_q;
  logic [15:0]             len_nxt;

  always_comb begin
    len_t = (lenp_r >>> 26) + 68'sd32768;
    len_q = len_t >>> 16;
    if (len_q < 0) len_nxt = 16'h0000;
    else if (len_q > 68'sd65535) len_nxt = 16'hFFFF;
    else len_nxt = len_q[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lenp_r    <= (LP_W'(mag0 >>> 4)) * LP_W'(INV_GAIN);
      x14_r     <= pos_sat(wd_r[N-1].wx);
      y14_r     <= pos_sat(wd_r[N-1].wy);
      ur14_r    <= wd_r[N-1].unreach;
      ph14_r[0] <= phi[0];
      ph14_r[1] <= phi[1];
      ph14_r[2] <= ph2_r[PDLY-1];
      ph14_r[3] <= phi[2];
      ph14_r[4] <= phi[3];
      out_wheel_x     <= x14_r;
      out_wheel_y     <= y14_r;
      out_leg_length  <= len_nxt;
      out_leg_angle   <= ang_round(ph14_r[0]);
      out_angle_one   <= ang_round(ph14_r[1]);
      out_angle_two   <= ang_round(ph14_r[2]);
      out_angle_three <= ang_round(ph14_r[3]);
      out_angle_four  <= ang_round(ph14_r[4]);
      out_unreachable <= ur14_r;
    end
  end

endmodule

>>> rtl/fblfk_chk.sv
`include "five_bar_leg_forward_kinematics_macros.svh"

module fblfk_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_wheel_x,
  input logic signed [15:0] out_leg_angle,
  input logic               out_unreachable
);

  `FBL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_wheel_x) && $stable(out_leg_angle) && $stable(out_unreachable), "stalled item changed")
  `FBL_ASSERT_NOW(a_back_press, out_valid && out_stall, in_stall, "input taken while output blocked")
  `FBL_ASSERT_NOW(a_free_flow, !out_stall, !in_stall, "input stalled with output free")
  `FBL_ASSERT_RST(a_rst_empty, !out_valid, "item present after reset")

endmodule

bind five_bar_leg_forward_kinematics fblfk_chk u_fblfk_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_wheel_x(out_wheel_x),
  .out_leg_angle(out_leg_angle), .out_unreachable(out_unreachable)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fblfk_pkg::*;

  typedef struct {
    logic [15:0] f [9];
  } leg_pose_t;

  localparam longint INV_K = 64'sd652032874;
  localparam longint HALF = 64'sh8000_0000;
  localparam longint QUART = 64'sh4000_0000;
  localparam int STAGES = 16;
  localparam int SETTLE = 4 * STAGES + 60;

  const logic [31:0] atan_turns [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  const string field_names [9] = '{"wheel_x", "wheel_y", "leg_length", "leg_angle",
    "angle_one", "angle_two", "angle_three", "angle_four", "unreachable"};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_joint_a_angle = '0;
  logic signed [15:0] in_joint_b_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_wheel_x, out_wheel_y, out_leg_angle;
  logic signed [15:0] out_angle_one, out_angle_two, out_angle_three, out_angle_four;
  logic [15:0] out_leg_length;
  logic out_unreachable;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;

  longint link_len [5];
  leg_pose_t pending_poses [$];
  int mismatches = 0;
  int items_sent = 0;
  int poses_seen = 0;
  int cfg_writes = 0;
  bit idle_en = 1'b1;
  int hold_cycles = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  five_bar_leg_forward_kinematics dut (.*);

  function automatic longint atan_step(int i);
    logic [63:0] t;
    t = {32'h0, atan_turns[i]};
    t = ((t + 64'h8000) >> 16) << 16;
    return longint'(t);
  endfunction

  function automatic void cordic_rotate(input logic [31:0] ang, output longint c,
                                        output longint s);
    longint z, x, y, ex, ey;
    z = longint'($signed(ang));
    x = INV_K;
    y = 0;
    if (z > QUART) begin
      z -= HALF;
      x = -INV_K;
    end else if (z < -QUART) begin
      z += HALF;
      x = -INV_K;
    end
    for (int i = 0; i < STAGES; i++) begin
      ex = y >>> i;
      ey = x >>> i;
      if (z >= 0) begin
        x -= ex; y += ey; z -= atan_step(i);
      end else begin
        x += ex; y -= ey; z += atan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic logic [31:0] cordic_vector(input longint xi, input longint yi,
                                                output longint mag);
    longint x, y, z, ex, ey;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 32'h0;
    end
    if (x < 0) begin
      x = -x; y = -y; z = HALF;
    end
    for (int i = 0; i < STAGES; i++) begin
      ex = y >>> i;
      ey = x >>> i;
      if (y < 0) begin
        x -= ex; y += ey; z -= atan_step(i);
      end else begin
        x += ex; y -= ey; z += atan_step(i);
      end
    end
    mag = x;
    return z[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] pos_round(longint q);
    longint v;
    v = (q + 32768) >>> 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] turn_round(logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  function automatic leg_pose_t solve_leg(logic [15:0] ja, logic [15:0] jb);
    leg_pose_t p;
    longint l1, l2, l3, l4, l5, c1, s1, c4, s4, c2, s2, xb, yb, xd, yd, dx, dy;
    longint dx8, dy8, a, b, c, m, an, bn, cn, d, r, wx, wy, mag, len, dummy;
    logic [31:0] half, phi0, phi1, phi2, phi3, phi4;
    int sh;
    bit unreach;
    l1 = link_len[REG_UPPER_A]; l2 = link_len[REG_LOWER_A];
    l3 = link_len[REG_LOWER_B]; l4 = link_len[REG_UPPER_B];
    l5 = link_len[REG_SPACING];
    cordic_rotate({ja, 16'h0}, c1, s1);
    cordic_rotate({jb, 16'h0}, c4, s4);
    xb = (l1 * c1) >>> 14;
    yb = (l1 * s1) >>> 14;
    xd = l5 * 65536 + ((l4 * c4) >>> 14);
    yd = (l4 * s4) >>> 14;
    dx = xd - xb;
    dy = yd - yb;
    a = 2 * l2 * dx;
    b = 2 * l2 * dy;
    dx8 = dx >>> 8;
    dy8 = dy >>> 8;
    c = (l2 * l2 - l3 * l3) * 65536 + dx8 * dx8 + dy8 * dy8;
    m = (a < 0) ? -a : a;
    if (((b < 0) ? -b : b) > m) m = (b < 0) ? -b : b;
    if (((c < 0) ? -c : c) > m) m = (c < 0) ? -c : c;
    sh = 0;
    while ((m >> sh) >= (64'sd1 << 30)) sh++;
    an = a >>> sh;
    bn = b >>> sh;
    cn = c >>> sh;
    d = an * an + bn * bn - cn * cn;
    unreach = d < 0;
    if (unreach) d = 0;
    r = longint'(floor_sqrt(d));
    half = cordic_vector(an + cn, bn + r, dummy);
    phi2 = half * 2;
    cordic_rotate(phi2, c2, s2);
    wx = xb + ((l2 * c2) >>> 14);
    wy = yb + ((l2 * s2) >>> 14);
    phi0 = cordic_vector(wx - l5 * 32768, wy, mag);
    len = ((mag >>> 4) * INV_K) >>> 26;
    len = (len + 32768) >>> 16;
    if (len < 0) len = 0;
    if (len > 65535) len = 65535;
    phi1 = cordic_vector(xb, yb, dummy);
    phi3 = cordic_vector(wx - xd, wy - yd, dummy);
    phi4 = cordic_vector(xd - l5 * 65536, yd, dummy);
    p.f[0] = pos_round(wx);
    p.f[1] = pos_round(wy);
    p.f[2] = len[15:0];
    p.f[3] = turn_round(phi0);
    p.f[4] = turn_round(phi1);
    p.f[5] = turn_round(phi2);
    p.f[6] = turn_round(phi3);
    p.f[7] = turn_round(phi4);
    p.f[8] = {15'h0, unreach};
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %0t %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    leg_pose_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.f = '{out_wheel_x, out_wheel_y, out_leg_length, out_leg_angle, out_angle_one,
                out_angle_two, out_angle_three, out_angle_four, {15'h0, out_unreachable}};
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected item", got.f[0], 16'h0);
      end else begin
        want = pending_poses.pop_front();
        poses_seen++;
        for (int i = 0; i < 9; i++)
          if (got.f[i] !== want.f[i]) report_mismatch(field_names[i], got.f[i], want.f[i]);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  task automatic send_angles(logic [15:0] ja, logic [15:0] jb);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_a_angle <= ja;
    in_joint_b_angle <= jb;
    do @(posedge clk); while (in_stall);
    pending_poses.push_back(solve_leg(ja, jb));
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_link(logic [2:0] idx, logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    link_len[idx] = longint'(val);
    cfg_writes++;
  endtask

  task automatic set_links(logic [LEN_W-1:0] ua, logic [LEN_W-1:0] la,
                           logic [LEN_W-1:0] lb, logic [LEN_W-1:0] ub,
                           logic [LEN_W-1:0] sp);
    drain();
    write_link(REG_UPPER_A, ua);
    write_link(REG_LOWER_A, la);
    write_link(REG_LOWER_B, lb);
    write_link(REG_UPPER_B, ub);
    write_link(REG_SPACING, sp);
  endtask

  task automatic test_directed;
    logic [15:0] corners [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000,
                                 16'h0001, 16'hFFFF, 16'h2000};
    for (int i = 0; i < 8; i++) send_angles(corners[i], corners[7 - i]);
    for (int i = 0; i < 8; i++) send_angles(corners[i], corners[i]);
    send_angles(16'h0000, 16'h8000);
    send_angles(16'h8000, 16'h0000);
    send_angles(16'hAAAA, 16'h5555);
  endtask

  task automatic test_link_extremes;
    set_links(14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
    send_angles(16'h0000, 16'h0000);
    send_angles(16'h4000, 16'hC000);
    set_links(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    for (int i = 0; i < 6; i++) send_angles(16'($urandom), 16'($urandom));
    send_angles(16'h8000, 16'h0000);
    set_links(14'd1500, 14'd100, 14'd100, 14'd1500, 14'd3000);
    send_angles(16'h8000, 16'h0000);
    send_angles(16'($urandom), 16'($urandom));
    set_links(14'd1500, 14'd2500, 14'd2500, 14'd1500, 14'd1000);
  endtask

  task automatic test_random_links;
    for (int k = 0; k < 6; k++) begin
      set_links(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                14'($urandom));
      repeat (60) send_angles(16'($urandom), 16'($urandom));
    end
    set_links(14'd1500, 14'd2500, 14'd2500, 14'd1500, 14'd1000);
  endtask

  task automatic test_random_angles;
    repeat (1000) begin
      if ($urandom_range(0, 3) == 0) send_angles(16'($urandom), 16'($urandom));
      else send_angles(16'(16'hC000 + $urandom_range(0, 16383)),
                       16'(16'hC000 + $urandom_range(0, 16383)));
    end
  endtask

  task automatic test_backpressure;
    hold_cycles = 400;
    repeat (300) send_angles(16'($urandom), 16'($urandom));
  endtask

  task automatic test_streaming;
    idle_en = 1'b0;
    repeat (250) send_angles(16'($urandom), 16'($urandom));
  endtask

  initial begin
    link_len = '{1500, 2500, 2500, 1500, 1000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_link_extremes();
    test_random_links();
    test_random_angles();
    test_backpressure();
    test_streaming();
    drain();
    $display("Ran %0d leg angle pairs, checked %0d poses, %0d link length writes",
             items_sent, poses_seen, cfg_writes);
    $display("covered zero and full scale links, unreachable poses, long output hold-off");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fblfk_pkg.sv
rtl/fblfk_rot.sv
rtl/fblfk_vec.sv
rtl/fblfk_sqrt.sv
rtl/five_bar_leg_forward_kinematics.sv
rtl/fblfk_chk.sv
tb/sv/tb_top.sv
